>>> hdl/bdasc_pkg.sv
package bdasc_pkg;
   localparam int ValueWidth = 32;
   localparam int CharWidth = 6;
   localparam int DefaultMaxDigits = 10;
   localparam int ValueDigits = 10;
   localparam logic [CharWidth-1:0] AsciiZero = 6'd48;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
   } req_type;

   typedef struct packed {
      logic [CharWidth-1:0] character;
      logic                 last;
   } rsp_type;
endpackage

>>> hdl/bdasc_if.sv
interface bdasc_req_if;
   import bdasc_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bdasc_rsp_if;
   import bdasc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hdl/binary_to_decimal_ascii.sv
// Converts an unsigned 32-bit number into its decimal digits as ASCII
// characters, most significant first, without leading zeros; zero gives a
// single '0', and the final character of each number carries last. A number
// passes through a 32-stage double-dabble pipeline, one shift-and-adjust per
// stage, then a digit register that emits one character per cycle while
// rsp.ready is high. A new number can enter each cycle the pipeline moves;
// the emitter holds a number until all of its digits (one to ten) are taken,
// so sustained rate is set by the digit count. Digits above MAX_DIGITS are
// dropped.
module binary_to_decimal_ascii #(
   parameter int MAX_DIGITS = bdasc_pkg::DefaultMaxDigits
) (
   input logic clock,
   input logic reset,
   bdasc_req_if.sink   req,
   bdasc_rsp_if.source rsp
);
   import bdasc_pkg::*;

   localparam int Stages = ValueWidth;
   localparam int BcdWidth = 4 * ValueDigits;
   localparam int NumDigits = (MAX_DIGITS < ValueDigits) ? MAX_DIGITS : ValueDigits;
   localparam int CntWidth = $clog2(NumDigits + 1);
   localparam int IdxWidth = (NumDigits > 1) ? $clog2(NumDigits) : 1;

   logic [Stages:0]          vld_ff;
   logic [ValueWidth-1:0]    bin_ff [Stages+1];
   logic [BcdWidth-1:0]      bcd_ff [Stages+1];
   logic                     advance;

   logic [3:0]               dig_ff [NumDigits];
   logic [3:0]               dig_in [NumDigits];
   logic [CntWidth-1:0]      cnt_ff, cnt_in;
   logic                     busy_ff;
   logic                     load;
   logic [CntWidth-1:0]      ndig;
   logic [IdxWidth-1:0]      idx;

   assign load = vld_ff[Stages] && (!busy_ff || (rsp.ready && cnt_ff == CntWidth'(1)));
   assign advance = !vld_ff[Stages] || load;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Stages-1:0], req.valid};
      end
   end

   always_comb begin
      for (int d = 0; d < NumDigits; d++) begin
         dig_in[d] = bcd_ff[Stages][4*d +: 4];
      end
      ndig = CntWidth'(1);
      for (int d = 1; d < NumDigits; d++) begin
         if ((bcd_ff[Stages] >> (4 * d)) != '0) begin
            ndig = CntWidth'(d + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bin_ff[0] <= req.data.value;
         bcd_ff[0] <= '0;
         for (int s = 0; s < Stages; s++) begin
            logic [BcdWidth-1:0] adj;
            adj = bcd_ff[s];
            for (int d = 0; d < ValueDigits; d++) begin
               if (adj[4*d +: 4] >= 4'd5) begin
                  adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
               end
            end
            bcd_ff[s+1] <= {adj[BcdWidth-2:0], bin_ff[s][ValueWidth-1]};
            bin_ff[s+1] <= {bin_ff[s][ValueWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         cnt_ff <= ndig;
      end else if (busy_ff && rsp.ready) begin
         cnt_ff <= cnt_ff - CntWidth'(1);
         busy_ff <= (cnt_ff != CntWidth'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dig_ff <= dig_in;
      end
   end

   assign idx = IdxWidth'(cnt_ff - CntWidth'(1));
   assign rsp.valid = busy_ff;
   assign rsp.data.character = AsciiZero + CharWidth'(dig_ff[idx]);
   assign rsp.data.last = (cnt_ff == CntWidth'(1));
endmodule

>>> hdl/bdasc_checker.sv
module bdasc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_character,
   input logic        rsp_last
);
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character >= 6'd48 && rsp_character <= 6'd57))
      else $error("character out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled result changed");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid [*33])
      else $error("result before pipeline fill");

   a_next_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("digit run broken");
endmodule

bind binary_to_decimal_ascii bdasc_checker u_bdasc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_character(rsp.data.character),
   .rsp_last(rsp.data.last)
);
